// ----- src/drt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the divider and reload timer
// Word layouts, register indexes, sequencer states and divider sizes.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int DIV_PERIOD = 64;
  localparam int ELAPSED_W  = 20;
  localparam int RES_W      = 32;
  localparam int PER_W      = 11;
  localparam int PERIOD_MAX = 1024;
  localparam int DVD_W      = 34;
  localparam int DIV_STEPS  = DVD_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int BUDGET_W   = 31;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_RELOAD = 2'd2
  } drt_cfg_e;

  typedef enum logic {
    OP_STEP = 1'b0,
    OP_IDLE = 1'b1
  } drt_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_TDIV,
    ST_FOLD,
    ST_BUDGET
  } drt_state_e;

  typedef struct packed {
    logic                 opcode;
    logic [ELAPSED_W-1:0] elapsed;
  } drt_in_t;

  typedef struct packed {
    logic [7:0]          divider_value;
    logic [7:0]          timer_value;
    logic                timer_irq;
    logic [BUDGET_W-1:0] idle_budget;
  } drt_out_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } drt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [PER_W-1:0] remainder;
  } drt_div_rsp_t;

endpackage

// ----- src/drt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drt_div: shared unsigned divider
// Restoring division, two quotient bits per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module drt_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drt_pkg::drt_div_req_t req_i,
  output drt_pkg::drt_div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [drt_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [drt_pkg::DVD_W-1:0]   quo_q, quo_d;
  logic [drt_pkg::PER_W-1:0]   rem_q, rem_d;
  logic [drt_pkg::PER_W-1:0]   dvs_q, dvs_d;

  logic [drt_pkg::PER_W:0]     r1, r1n, r2, r2n;
  logic                        ge1, ge2;
  logic                        last;

  assign last = (cnt_q == drt_pkg::CNT_W'(drt_pkg::DIV_STEPS - 1));

  always_comb begin
    r1  = {rem_q, quo_q[drt_pkg::DVD_W-1]};
    ge1 = (r1 >= {1'b0, dvs_q});
    r1n = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
    r2  = {r1n[drt_pkg::PER_W-1:0], quo_q[drt_pkg::DVD_W-2]};
    ge2 = (r2 >= {1'b0, dvs_q});
    r2n = ge2 ? (r2 - {1'b0, dvs_q}) : r2;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // shift dividend bits out the top, quotient bits in at the bottom
      quo_d = {quo_q[drt_pkg::DVD_W-3:0], ge1, ge2};
      rem_d = r2n[drt_pkg::PER_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- src/divider_and_reload_timer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_and_reload_timer_top: cycle-driven divider and reloading timer
// Advances an 8-bit divider and an 8-bit reloading timer by elapsed cycles,
// at most one count per word in step mode or many counts by division in idle mode.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o | in_word_i  (drt_in_t)
//  out     | output    | out_valid_o/out_stall_i | out_word_o (drt_out_t)
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A step word, or an idle word with the timer frozen, goes through ST_CALC and
// ST_BUDGET from accept to the output register. An idle word with the timer
// running makes two passes through the shared divider, in ST_TDIV and ST_FOLD,
// at two quotient bits a cycle (a load and 17 steps each). The next word is
// accepted in the cycle after the output register is written. Reset restores
// the register and counter defaults at once. A result waiting under out_stall_i
// does not block the next accept; only its own output register write waits.
// ----------------------------------------------------------------------------
module divider_and_reload_timer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drt_pkg::drt_in_t   in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drt_pkg::drt_out_t  out_word_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [10:0]        cfg_data_i
);

  localparam int W = drt_pkg::DVD_W;

  drt_pkg::drt_state_e state_q, state_d;
  drt_pkg::drt_in_t    word_q, word_d;
  drt_pkg::drt_out_t   out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                      en_q;
  logic [drt_pkg::PER_W-1:0] period_q;
  logic [7:0]                reload_q;

  logic [7:0]                dcnt_q, dcnt_d;
  logic [drt_pkg::RES_W-1:0] dres_q, dres_d;
  logic [7:0]                tcnt_q, tcnt_d;
  logic [drt_pkg::RES_W-1:0] tres_q, tres_d;
  logic                      irq_q, irq_d;
  logic                      neg_q, neg_d;

  drt_pkg::drt_div_req_t div_req;
  drt_pkg::drt_div_rsp_t div_rsp;

  logic [drt_pkg::PER_W-1:0] per;
  logic [8:0]                span;
  logic [W-1:0]              cyc, sdres, stres;
  logic [W-1:0]              dr, tr, xd, magd, qd, rd, xt, counts, t, y;
  logic [18:0]               prod;
  logic [W-1:0]              bud;

  // effective period: zero acts as one, clip at the top
  always_comb begin
    if (period_q == '0) begin
      per = drt_pkg::PER_W'(1);
    end else if (period_q > drt_pkg::PER_W'(drt_pkg::PERIOD_MAX)) begin
      per = drt_pkg::PER_W'(drt_pkg::PERIOD_MAX);
    end else begin
      per = period_q;
    end
  end

  assign span  = 9'd256 - {1'b0, reload_q};
  assign cyc   = {{(W - drt_pkg::ELAPSED_W){1'b0}}, word_q.elapsed};
  assign sdres = {{(W - drt_pkg::RES_W){dres_q[drt_pkg::RES_W-1]}}, dres_q};
  assign stres = {{(W - drt_pkg::RES_W){tres_q[drt_pkg::RES_W-1]}}, tres_q};

  always_comb begin
    prod = (8'd255 - tcnt_q) * per;
    bud  = stres + {{(W - 19){1'b0}}, prod};
  end

  always_comb begin
    state_d     = state_q;
    word_d      = word_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    dcnt_d      = dcnt_q;
    dres_d      = dres_q;
    tcnt_d      = tcnt_q;
    tres_d      = tres_q;
    irq_d       = irq_q;
    neg_d       = neg_q;
    div_req     = '0;
    dr          = '0;
    tr          = '0;
    xd          = '0;
    magd        = '0;
    qd          = '0;
    rd          = '0;
    xt          = '0;
    counts      = '0;
    t           = '0;
    y           = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      drt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          word_d  = in_word_i;
          state_d = drt_pkg::ST_CALC;
        end
      end

      drt_pkg::ST_CALC: begin
        irq_d = 1'b0;
        if (word_q.opcode == drt_pkg::OP_STEP) begin
          dr = sdres - cyc;
          if (dr[W-1] || dr == '0) begin
            dcnt_d = dcnt_q + 8'd1;
            dr     = dr + W'(drt_pkg::DIV_PERIOD);
          end
          dres_d = dr[drt_pkg::RES_W-1:0];
          if (en_q) begin
            tr = stres - cyc;
            if (tr[W-1] || tr == '0) begin
              tr = tr + {{(W - drt_pkg::PER_W){1'b0}}, per};
              if (tcnt_q == 8'hFF) begin
                tcnt_d = reload_q;
                irq_d  = 1'b1;
              end else begin
                tcnt_d = tcnt_q + 8'd1;
              end
            end
            tres_d = tr[drt_pkg::RES_W-1:0];
          end
          state_d = drt_pkg::ST_BUDGET;
        end else begin
          // divider period is a power of two: shift and mask on the magnitude
          xd   = W'(drt_pkg::DIV_PERIOD) - sdres + cyc;
          magd = xd[W-1] ? -xd : xd;
          qd   = magd / drt_pkg::DIV_PERIOD;
          rd   = magd % drt_pkg::DIV_PERIOD;
          if (xd[W-1]) begin
            dres_d = drt_pkg::RES_W'(drt_pkg::DIV_PERIOD) + rd[drt_pkg::RES_W-1:0];
            dcnt_d = dcnt_q - qd[7:0];
          end else begin
            dres_d = drt_pkg::RES_W'(drt_pkg::DIV_PERIOD) - rd[drt_pkg::RES_W-1:0];
            dcnt_d = dcnt_q + qd[7:0];
          end
          if (en_q) begin
            xt               = {{(W - drt_pkg::PER_W){1'b0}}, per} - stres + cyc;
            neg_d            = xt[W-1];
            div_req.start    = 1'b1;
            div_req.dividend = xt[W-1] ? -xt : xt;
            div_req.divisor  = per;
            state_d          = drt_pkg::ST_TDIV;
          end else begin
            state_d = drt_pkg::ST_BUDGET;
          end
        end
      end

      drt_pkg::ST_TDIV: begin
        if (div_rsp.done) begin
          counts = neg_q ? -div_rsp.quotient : div_rsp.quotient;
          if (neg_q) begin
            tres_d = drt_pkg::RES_W'(per) + drt_pkg::RES_W'(div_rsp.remainder);
          end else begin
            tres_d = drt_pkg::RES_W'(per) - drt_pkg::RES_W'(div_rsp.remainder);
          end
          // overflow when count plus advance passes 255
          t     = counts + {{(W - 8){1'b0}}, tcnt_q} - W'(255);
          irq_d = !t[W-1] && (t != '0);
          // fold the advance over the reload span, truncating remainder
          y = {{(W - 8){1'b0}}, tcnt_q} - {{(W - 8){1'b0}}, reload_q} + counts;
          neg_d            = y[W-1];
          div_req.start    = 1'b1;
          div_req.dividend = y[W-1] ? -y : y;
          div_req.divisor  = {{(drt_pkg::PER_W - 9){1'b0}}, span};
          state_d          = drt_pkg::ST_FOLD;
        end
      end

      drt_pkg::ST_FOLD: begin
        if (div_rsp.done) begin
          if (neg_q) begin
            tcnt_d = reload_q - div_rsp.remainder[7:0];
          end else begin
            tcnt_d = reload_q + div_rsp.remainder[7:0];
          end
          state_d = drt_pkg::ST_BUDGET;
        end
      end

      drt_pkg::ST_BUDGET: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d.divider_value = dcnt_q;
          out_d.timer_value   = tcnt_q;
          out_d.timer_irq     = irq_q;
          if (!en_q) begin
            out_d.idle_budget = '1;
          end else if (bud[W-1]) begin
            out_d.idle_budget = '0;
          end else if (bud[W-2:drt_pkg::BUDGET_W] != '0) begin
            out_d.idle_budget = '1;
          end else begin
            out_d.idle_budget = bud[drt_pkg::BUDGET_W-1:0];
          end
          out_valid_d = 1'b1;
          state_d     = drt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = drt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      dres_q      <= drt_pkg::RES_W'(drt_pkg::DIV_PERIOD);
      tcnt_q      <= '0;
      tres_q      <= drt_pkg::RES_W'(256);
      irq_q       <= 1'b0;
      neg_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
      dres_q      <= dres_d;
      tcnt_q      <= tcnt_d;
      tres_q      <= tres_d;
      irq_q       <= irq_d;
      neg_q       <= neg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b0;
      period_q <= drt_pkg::PER_W'(256);
      reload_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        drt_pkg::CFG_ENABLE: en_q     <= cfg_data_i[0];
        drt_pkg::CFG_PERIOD: period_q <= cfg_data_i;
        drt_pkg::CFG_RELOAD: reload_q <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    out_q  <= out_d;
  end

  drt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != drt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for divider_and_reload_timer_top
// Sends step and idle words through the valid/stall channels. A local model of
// the divider and the reloading timer predicts every result word, and each
// word out is compared field by field. Named tasks cover the corner cases, random
// register settings, output back-pressure and deeply negative residue registers.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0]                   CFG_SPARE  = 2'd3;  // unmapped register index
  localparam logic [drt_pkg::BUDGET_W-1:0] BUDGET_MAX = 31'h7FFFFFFF;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  drt_pkg::drt_in_t          in_word_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  drt_pkg::drt_out_t         out_word_o;
  logic                      cfg_we_i    = 1'b0;
  logic [1:0]                cfg_idx_i   = '0;
  logic [drt_pkg::PER_W-1:0] cfg_data_i  = '0;

  always #10 clk_i = ~clk_i;

  divider_and_reload_timer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Local copy of registers and counters
  logic                      en_q     = 1'b0;
  logic [drt_pkg::PER_W-1:0] period_q = 11'd256;
  logic [7:0]                reload_q = 8'd0;
  logic [7:0]                div_cnt  = 8'd0;
  logic [7:0]                tmr_cnt  = 8'd0;
  logic [31:0]               div_res  = 32'(drt_pkg::DIV_PERIOD);
  logic [31:0]               tmr_res  = 32'd256;

  drt_pkg::drt_out_t pending_results[$];
  int       errors       = 0;
  int       words_sent   = 0;
  int       results_seen = 0;
  int       irqs_seen    = 0;
  int       reg_writes   = 0;
  bit       idling       = 1'b1;
  int       hold_request = 0;
  int       hold_left    = 0;

  function automatic longint period_eff();
    if (period_q == '0) return 1;
    if (period_q > drt_pkg::PERIOD_MAX) return drt_pkg::PERIOD_MAX;
    return longint'(period_q);
  endfunction

  // Advance the local counters by one word and return the result word it makes
  function automatic drt_pkg::drt_out_t advance_counters(drt_pkg::drt_op_e op, longint cyc);
    longint            per;
    longint            r;
    longint            x;
    longint            counts;
    longint            folded;
    logic              irq;
    drt_pkg::drt_out_t res;
    per = period_eff();
    irq = 1'b0;
    if (op == drt_pkg::OP_STEP) begin
      r = longint'($signed(div_res)) - cyc;
      if (r <= 0) begin
        div_cnt = div_cnt + 8'd1;
        r = r + drt_pkg::DIV_PERIOD;
      end
      div_res = r[31:0];
      if (en_q) begin
        r = longint'($signed(tmr_res)) - cyc;
        if (r <= 0) begin
          r = r + per;
          tmr_cnt = tmr_cnt + 8'd1;
          if (tmr_cnt == 8'd0) begin
            tmr_cnt = reload_q;
            irq = 1'b1;
          end
        end
        tmr_res = r[31:0];
      end
    end else begin
      // truncating division: a residue above the period moves counts backward
      x = (drt_pkg::DIV_PERIOD - longint'($signed(div_res))) + cyc;
      r = drt_pkg::DIV_PERIOD - x % drt_pkg::DIV_PERIOD;
      div_res = r[31:0];
      r = longint'(div_cnt) + x / drt_pkg::DIV_PERIOD;
      div_cnt = r[7:0];
      if (en_q) begin
        x = (per - longint'($signed(tmr_res))) + cyc;
        counts = x / per;
        if (longint'(tmr_cnt) + counts > 255) irq = 1'b1;
        folded = ((longint'(tmr_cnt) - longint'(reload_q)) + counts)
                 % (256 - longint'(reload_q));
        r = folded + longint'(reload_q);
        tmr_cnt = r[7:0];
        r = per - x % per;
        tmr_res = r[31:0];
      end
    end
    res.divider_value = div_cnt;
    res.timer_value   = tmr_cnt;
    res.timer_irq     = irq;
    if (!en_q) begin
      res.idle_budget = BUDGET_MAX;
    end else begin
      r = longint'($signed(tmr_res)) + (255 - longint'(tmr_cnt)) * per;
      if (r < 0) res.idle_budget = '0;
      else if (r > longint'(BUDGET_MAX)) res.idle_budget = BUDGET_MAX;
      else res.idle_budget = r[drt_pkg::BUDGET_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [drt_pkg::ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return drt_pkg::ELAPSED_W'($urandom_range(0, 600));
      5, 6:          return drt_pkg::ELAPSED_W'($urandom_range(0, 70000));
      7:             return $urandom_range(1) ? '1 : '0;
      default:       return drt_pkg::ELAPSED_W'($urandom());
    endcase
  endfunction

  // Offer one word, hold it until accepted, then log its predicted result
  task automatic send_word(drt_pkg::drt_op_e op, logic [drt_pkg::ELAPSED_W-1:0] cycles);
    drt_pkg::drt_out_t want;
    while (idling && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= {op, cycles};
    do @(posedge clk_i); while (in_stall_o);
    want = advance_counters(op, longint'(cycles));
    pending_results.push_back(want);
    words_sent++;
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [drt_pkg::PER_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      drt_pkg::CFG_ENABLE: en_q = value[0];
      drt_pkg::CFG_PERIOD: period_q = value;
      drt_pkg::CFG_RELOAD: reload_q = value[7:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_random_config();
    logic [drt_pkg::PER_W-1:0] per;
    logic [7:0]                rld;
    case ($urandom_range(7))
      0:       per = 11'd1;
      1:       per = 11'd1024;
      2:       per = 11'd0;
      3:       per = 11'h7FF;
      4:       per = 11'd256;
      5:       per = drt_pkg::PER_W'($urandom_range(1, 16));
      6:       per = drt_pkg::PER_W'($urandom_range(1, 1024));
      default: per = drt_pkg::PER_W'($urandom_range(0, 2047));
    endcase
    case ($urandom_range(3))
      0:       rld = 8'd0;
      1:       rld = 8'd255;
      default: rld = 8'($urandom_range(0, 255));
    endcase
    write_reg(drt_pkg::CFG_PERIOD, per);
    // upper data bits are junk the block must drop
    write_reg(drt_pkg::CFG_RELOAD, {3'($urandom()), rld});
    write_reg(drt_pkg::CFG_ENABLE, {10'($urandom()), 1'($urandom_range(3) != 0)});
  endtask

  task automatic test_directed();
    // timer frozen after reset
    send_word(drt_pkg::OP_STEP, '0);
    send_word(drt_pkg::OP_STEP, '1);
    send_word(drt_pkg::OP_IDLE, '0);
    send_word(drt_pkg::OP_IDLE, '1);
    wait_all_results();
    write_reg(drt_pkg::CFG_ENABLE, 11'd1);
    write_reg(drt_pkg::CFG_PERIOD, 11'd1);
    // timer residue still holds 256, far above the new period
    send_word(drt_pkg::OP_IDLE, 20'd5);
    send_word(drt_pkg::OP_STEP, 20'd1);
    send_word(drt_pkg::OP_IDLE, 20'd300);
    send_word(drt_pkg::OP_IDLE, '1);
    wait_all_results();
    write_reg(drt_pkg::CFG_PERIOD, 11'd0);
    send_word(drt_pkg::OP_STEP, 20'd0);
    send_word(drt_pkg::OP_IDLE, 20'd1000);
    wait_all_results();
    write_reg(drt_pkg::CFG_PERIOD, 11'h7FF);
    send_word(drt_pkg::OP_IDLE, '1);
    send_word(drt_pkg::OP_STEP, 20'd2000);
    wait_all_results();
    write_reg(drt_pkg::CFG_RELOAD, 11'd255);
    write_reg(drt_pkg::CFG_PERIOD, 11'd4);
    send_word(drt_pkg::OP_IDLE, 20'd100);
    send_word(drt_pkg::OP_STEP, 20'd4);
    send_word(drt_pkg::OP_STEP, 20'd4);
    wait_all_results();
    write_reg(drt_pkg::CFG_RELOAD, 11'd0);
    send_word(drt_pkg::OP_IDLE, 20'd40);
    wait_all_results();
    // raise reload above the running timer, then fold an idle advance
    write_reg(drt_pkg::CFG_RELOAD, 11'd200);
    send_word(drt_pkg::OP_IDLE, 20'd1200);
    wait_all_results();
    write_reg(CFG_SPARE, 11'h7FF);
    send_word(drt_pkg::OP_STEP, 20'd1);
    wait_all_results();
    write_reg(drt_pkg::CFG_ENABLE, 11'd0);
    send_word(drt_pkg::OP_IDLE, 20'd777);
    send_word(drt_pkg::OP_STEP, 20'd64);
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 5; phase++) begin
      wait_all_results();
      idling = (phase != 0);
      set_random_config();
      repeat (100) send_word(drt_pkg::drt_op_e'($urandom_range(1)), pick_elapsed());
    end
    idling = 1'b1;
  endtask

  task automatic test_backpressure();
    wait_all_results();
    idling = 1'b0;
    hold_request = 300;
    repeat (40) begin
      send_word(drt_pkg::drt_op_e'($urandom_range(3) == 0),
                drt_pkg::ELAPSED_W'($urandom_range(0, 200)));
    end
    wait_all_results();
    idling = 1'b1;
  endtask

  task automatic test_deep_residue();
    wait_all_results();
    write_reg(drt_pkg::CFG_ENABLE, 11'd1);
    write_reg(drt_pkg::CFG_PERIOD, 11'd1024);
    write_reg(drt_pkg::CFG_RELOAD, 11'd0);
    // each full step sinks both residues by about 2^20, far below zero
    repeat (120) send_word(drt_pkg::OP_STEP, '1);
    repeat (20) send_word(drt_pkg::drt_op_e'($urandom_range(1)), pick_elapsed());
  endtask

  // Receiver: long hold on request, else random stall
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= idling && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk_i) begin : check_result
    drt_pkg::drt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: %p", out_word_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (want.timer_irq) irqs_seen++;
        if (out_word_o.divider_value !== want.divider_value) begin
          $error("divider_value expected %0d got %0d", want.divider_value,
                 out_word_o.divider_value);
          errors++;
        end
        if (out_word_o.timer_value !== want.timer_value) begin
          $error("timer_value expected %0d got %0d", want.timer_value,
                 out_word_o.timer_value);
          errors++;
        end
        if (out_word_o.timer_irq !== want.timer_irq) begin
          $error("timer_irq expected %0d got %0d", want.timer_irq, out_word_o.timer_irq);
          errors++;
        end
        if (out_word_o.idle_budget !== want.idle_budget) begin
          $error("idle_budget expected %0d got %0d", want.idle_budget,
                 out_word_o.idle_budget);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_configs();
    test_backpressure();
    test_deep_residue();
    wait_all_results();
    repeat (64) @(posedge clk_i);
    $display("Ran %0d words, checked %0d results with %0d timer interrupts, %0d register writes",
             words_sent, results_seen, irqs_seen, reg_writes);
    $display("Step and idle modes, period clamp, reload fold, negative residues, back-pressure");
    if (errors == 0) begin
      $display("divider_and_reload_timer_top verification clean");
    end else begin
      $display("divider_and_reload_timer_top verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("divider_and_reload_timer_top verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/drt_pkg.sv
src/drt_div.sv
src/divider_and_reload_timer_top.sv
sim/tb.sv
